### rtl/core/differential_drive_odometry_unit_assert.svh
// Assertion macros for the odometry unit.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DDO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("odometry assertion failed");

// Next-cycle implication.
`define DDO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("odometry assertion failed");

`endif

### rtl/core/ddo_pkg.sv
// Shared types and constants of the odometry unit.
`timescale 1ns / 1ps
package ddo_pkg;

   localparam int NUM_W   = 51;
   localparam int DEN_W   = 35;
   localparam int ITER_W  = 6;
   localparam int TRIG_W  = 19;
   localparam int CNT_W   = 5;
   localparam int ATAN_LEN = 24;
   localparam int MA_W    = 25;
   localparam int MB_W    = 19;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int PATH_W  = 47;

   localparam logic [ITER_W-1:0] DIV_A_ITERS = 6'd34;
   localparam logic [ITER_W-1:0] DIV_P_ITERS = 6'd51;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 19'sd39797;
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

   localparam logic [2:0] CSR_TICKS_TO_MM   = 3'd0;
   localparam logic [2:0] CSR_WHEEL_BASE    = 3'd1;
   localparam logic [2:0] CSR_START_X       = 3'd2;
   localparam logic [2:0] CSR_START_Y       = 3'd3;
   localparam logic [2:0] CSR_START_HEADING = 3'd4;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic              start;
      logic [ITER_W-1:0] iters;
   } div_req_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MUL_D, ST_MUL_S, ST_CHECK, ST_DIV_A, ST_PHASE, ST_TURN, ST_COR_A,
      ST_MS_LO, ST_MS_HI, ST_MS_ACC, ST_DIV_P, ST_HEAD, ST_COR_H, ST_MX_LO, ST_MX_HI,
      ST_MY_LO, ST_MY_HI, ST_MY_ACC, ST_OUT
   } state_type;

endpackage

### rtl/core/differential_drive_odometry_unit.sv
// Odometry unit top level: sequencer, pose and register file.
// A straight beat uses the CORDIC once; a vanishing turn adds a serial divide; a turning
// beat uses the serial divider and the CORDIC twice each.
// One beat at a time: req_stall holds until the result sits in
// the output register, which may still wait while the next beat is taken.
// Reset: synchronous; pose and start pose zero, scale 1.0 mm/tick, base 200 mm.
`timescale 1ns / 1ps
`include "differential_drive_odometry_unit_assert.svh"
module differential_drive_odometry_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [8:0]  req_left_ticks,
   input  logic signed [8:0]  req_right_ticks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic [15:0]        rsp_heading,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data
);
   import ddo_pkg::*;

   // trunc(v / 2^32) saturated to 16 bits
   function automatic logic signed [15:0] shrink(input logic signed [63:0] v);
      logic signed [31:0] q;
      q = v[63:32];
      if (v[63] && (v[31:0] != 32'd0)) begin
         q = q + 32'sd1;
      end
      if (q > 32'sd32767) begin
         return 16'sh7FFF;
      end else if (q < -32'sd32768) begin
         return -16'sh8000;
      end
      return q[15:0];
   endfunction

   state_type state_ff, state_in;

   // configuration and pose
   logic [23:0]        scale_ff, scale_in;
   logic [11:0]        wbase_ff, wbase_in;
   logic signed [15:0] start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [15:0]        start_hd_ff, start_hd_in;
   logic signed [15:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [15:0]        pose_hd_ff, pose_hd_in;

   // working registers of one beat
   logic signed [8:0]        left_ff, left_in, right_ff, right_in;
   logic signed [34:0]       ds_ff, ds_in, ss_ff, ss_in, a_ff, a_in;
   logic [61:0]              plo_ff, plo_in;
   logic [15:0]              phi_ff, phi_in;
   logic signed [TRIG_W-1:0] sin_a_ff, sin_a_in, cos_h_ff, cos_h_in, sin_h_ff, sin_h_in;
   logic signed [63:0]       acc_ff, acc_in;
   logic signed [PATH_W-1:0] path_ff, path_in;
   logic                     neg_ff, neg_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic [15:0]        out_hd_ff, out_hd_in;

   // shared units
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [63:0]       prod_x, prod_hi;
   div_req_type              div_req;
   logic [NUM_W-1:0]         div_num, quo;
   logic [DEN_W-1:0]         div_den;
   logic                     div_done;
   logic                     cor_start, cor_done;
   logic [31:0]              cor_phase;
   logic signed [TRIG_W-1:0] cor_cos, cor_sin;

   // helpers
   logic signed [9:0]  diff_v, sum_v;
   logic [11:0]        wb_eff;
   logic signed [34:0] ds_mag, a_mag, half_src;
   logic [35:0]        half_tmp;
   logic signed [PATH_W-1:0] half_path;
   logic [47:0]        a48, p48;
   logic signed [63:0] sum64, sum_mag;
   logic [45:0]        path_mag;
   logic               load_pose;

   ddo_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   ddo_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   ddo_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cor_start),
      .phase (cor_phase),
      .done  (cor_done),
      .cos_v (cor_cos),
      .sin_v (cor_sin)
   );

   always_comb begin
      diff_v  = {right_ff[8], right_ff} - {left_ff[8], left_ff};
      sum_v   = {right_ff[8], right_ff} + {left_ff[8], left_ff};
      wb_eff  = (wbase_ff == 12'd0) ? 12'd1 : wbase_ff;
      ds_mag  = ds_ff[34] ? (35'sd0 - ds_ff) : ds_ff;
      a_mag   = a_ff[34] ? (35'sd0 - a_ff) : a_ff;
      prod_x  = {{(64 - PROD_W){prod[PROD_W-1]}}, prod};
      prod_hi = {prod_x[39:0], 24'd0};
      // straight or vanishing turn: path = trunc(sum*scale / 2)
      half_src  = (state_ff == ST_CHECK) ? prod[34:0] : ss_ff;
      half_tmp  = {half_src[34], half_src} + {35'd0, half_src[34]};
      half_path = {{12{half_tmp[35]}}, half_tmp[35:1]};
      a48     = {{13{a_ff[34]}}, a_ff};
      p48     = plo_ff[47:0] + {phi_ff, 32'd0};
      sum64   = acc_ff + prod_hi;
      sum_mag = sum64[63] ? (64'sd0 - sum64) : sum64;
      // path saturates at 2^45 in magnitude
      if ((quo[50:46] != 5'd0) || (quo[45] && (quo[44:0] != 45'd0))) begin
         path_mag = 46'h2000_0000_0000;
      end else begin
         path_mag = quo[45:0];
      end

      state_in     = state_ff;
      scale_in     = scale_ff;
      wbase_in     = wbase_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      start_hd_in  = start_hd_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      pose_hd_in   = pose_hd_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      ds_in        = ds_ff;
      ss_in        = ss_ff;
      a_in         = a_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      sin_a_in     = sin_a_ff;
      cos_h_in     = cos_h_ff;
      sin_h_in     = sin_h_ff;
      acc_in       = acc_ff;
      path_in      = path_ff;
      neg_in       = neg_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_hd_in    = out_hd_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = '0;
      mul_b        = '0;
      div_req      = '0;
      div_num      = '0;
      div_den      = '0;
      cor_start    = 1'b0;
      cor_phase    = '0;
      load_pose    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               left_in  = req_left_ticks;
               right_in = req_right_ticks;
               state_in = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            mul_a    = {1'b0, scale_ff};
            mul_b    = MB_W'(diff_v);
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            ds_in    = prod[34:0];
            mul_a    = {1'b0, scale_ff};
            mul_b    = MB_W'(sum_v);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            ss_in = prod[34:0];
            if (left_ff == right_ff) begin
               path_in  = half_path;
               state_in = ST_HEAD;
            end else begin
               // turn angle alpha = d*scale / wheel base
               div_req.start = 1'b1;
               div_req.iters = DIV_A_ITERS;
               div_num       = {ds_mag[33:0], 17'd0};
               div_den       = {23'd0, wb_eff};
               state_in      = ST_DIV_A;
            end
         end
         ST_DIV_A: begin
            if (div_done) begin
               a_in = ds_ff[34] ? (35'sd0 - {1'b0, quo[33:0]}) : {1'b0, quo[33:0]};
               if (quo[33:0] == 34'd0) begin
                  path_in  = half_path;
                  state_in = ST_HEAD;
               end else begin
                  state_in = ST_PHASE;
               end
            end
         end
         ST_PHASE: begin
            // alpha in turns: only the low 48 bits of the product matter
            plo_in   = 62'(a_ff[31:0]) * 62'(INV_TWO_PI_Q32);
            phi_in   = 16'(a48[47:32] * INV_TWO_PI_Q32[15:0]);
            state_in = ST_TURN;
         end
         ST_TURN: begin
            pose_hd_in = pose_hd_ff + p48[47:32];
            cor_start  = 1'b1;
            cor_phase  = p48[47:16];
            state_in   = ST_COR_A;
         end
         ST_COR_A: begin
            if (cor_done) begin
               sin_a_in = cor_sin;
               state_in = ST_MS_LO;
            end
         end
         ST_MS_LO: begin
            mul_a    = {1'b0, ss_ff[23:0]};
            mul_b    = sin_a_ff;
            state_in = ST_MS_HI;
         end
         ST_MS_HI: begin
            acc_in   = prod_x;
            mul_a    = MA_W'($signed(ss_ff[34:24]));
            mul_b    = sin_a_ff;
            state_in = ST_MS_ACC;
         end
         ST_MS_ACC: begin
            // path = sin(alpha)*sum*scale / (2*alpha)
            div_req.start = 1'b1;
            div_req.iters = DIV_P_ITERS;
            div_num       = sum_mag[50:0];
            div_den       = {a_mag[33:0], 1'b0};
            neg_in        = sum64[63] ^ a_ff[34];
            state_in      = ST_DIV_P;
         end
         ST_DIV_P: begin
            if (div_done) begin
               path_in  = neg_ff ? (47'sd0 - {1'b0, path_mag}) : {1'b0, path_mag};
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            cor_start = 1'b1;
            cor_phase = {pose_hd_ff, 16'd0};
            state_in  = ST_COR_H;
         end
         ST_COR_H: begin
            if (cor_done) begin
               cos_h_in = cor_cos;
               sin_h_in = cor_sin;
               state_in = ST_MX_LO;
            end
         end
         ST_MX_LO: begin
            mul_a    = {1'b0, path_ff[23:0]};
            mul_b    = cos_h_ff;
            acc_in   = {{16{pose_x_ff[15]}}, pose_x_ff, 32'd0};
            state_in = ST_MX_HI;
         end
         ST_MX_HI: begin
            acc_in   = acc_ff + prod_x;
            mul_a    = MA_W'($signed(path_ff[46:24]));
            mul_b    = cos_h_ff;
            state_in = ST_MY_LO;
         end
         ST_MY_LO: begin
            pose_x_in = shrink(sum64);
            mul_a     = {1'b0, path_ff[23:0]};
            mul_b     = sin_h_ff;
            acc_in    = {{16{pose_y_ff[15]}}, pose_y_ff, 32'd0};
            state_in  = ST_MY_HI;
         end
         ST_MY_HI: begin
            acc_in   = acc_ff - prod_x;
            mul_a    = MA_W'($signed(path_ff[46:24]));
            mul_b    = sin_h_ff;
            state_in = ST_MY_ACC;
         end
         ST_MY_ACC: begin
            pose_y_in = shrink(acc_ff - prod_hi);
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_x_in     = pose_x_ff;
               out_y_in     = pose_y_ff;
               out_hd_in    = pose_hd_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes are to arrive only while idle; the block itself does not enforce it
      if (csr_valid) begin
         case (csr_index)
            CSR_TICKS_TO_MM:   scale_in = csr_data;
            CSR_WHEEL_BASE:    wbase_in = csr_data[11:0];
            CSR_START_X: begin
               start_x_in = csr_data[15:0];
               load_pose  = 1'b1;
            end
            CSR_START_Y: begin
               start_y_in = csr_data[15:0];
               load_pose  = 1'b1;
            end
            CSR_START_HEADING: begin
               start_hd_in = csr_data[15:0];
               load_pose   = 1'b1;
            end
            default: begin
               load_pose = 1'b0;
            end
         endcase
      end
      if (load_pose) begin
         pose_x_in  = start_x_in;
         pose_y_in  = start_y_in;
         pose_hd_in = start_hd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= 24'd65536;
         wbase_ff     <= 12'd200;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         start_hd_ff  <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_hd_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_ff     <= scale_in;
         wbase_ff     <= wbase_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         start_hd_ff  <= start_hd_in;
         pose_x_ff    <= pose_x_in;
         pose_y_ff    <= pose_y_in;
         pose_hd_ff   <= pose_hd_in;
      end
      left_ff   <= left_in;
      right_ff  <= right_in;
      ds_ff     <= ds_in;
      ss_ff     <= ss_in;
      a_ff      <= a_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      sin_a_ff  <= sin_a_in;
      cos_h_ff  <= cos_h_in;
      sin_h_ff  <= sin_h_in;
      acc_ff    <= acc_in;
      path_ff   <= path_in;
      neg_ff    <= neg_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_hd_ff <= out_hd_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = out_x_ff;
   assign rsp_pos_y   = out_y_ff;
   assign rsp_heading = out_hd_ff;

   // an accepted beat always starts the sequence
   `DDO_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff == ST_MUL_D)
   // divider finishes only while the sequencer waits for it
   `DDO_ASSERT_NOW(a_div_done_wait, clock, reset, div_done, state_ff == ST_DIV_A || state_ff == ST_DIV_P)
   // CORDIC finishes only while the sequencer waits for it
   `DDO_ASSERT_NOW(a_cor_done_wait, clock, reset, cor_done, state_ff == ST_COR_A || state_ff == ST_COR_H)
   // a held result is never overwritten
   `DDO_ASSERT_NEXT(a_out_waits, clock, reset, state_ff == ST_OUT && rsp_valid_ff && rsp_stall, state_ff == ST_OUT)

endmodule

### rtl/core/ddo_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module ddo_mul (
   input  logic                                clock,
   input  logic signed [ddo_pkg::MA_W-1:0]     mul_a,
   input  logic signed [ddo_pkg::MB_W-1:0]     mul_b,
   output logic signed [ddo_pkg::PROD_W-1:0]   prod
);
   import ddo_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### rtl/core/ddo_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
`timescale 1ns / 1ps
module ddo_div (
   input  logic                          clock,
   input  logic                          reset,
   input  ddo_pkg::div_req_type          req,
   input  logic [ddo_pkg::NUM_W-1:0]     num,
   input  logic [ddo_pkg::DEN_W-1:0]     den,
   output logic                          done,
   output logic [ddo_pkg::NUM_W-1:0]     quo
);
   import ddo_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    trial;
   logic              fits;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = req.iters;
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

### rtl/core/ddo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle.
`timescale 1ns / 1ps
module ddo_cordic #(
   parameter int STEPS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [31:0]                        phase,
   output logic                               done,
   output logic signed [ddo_pkg::TRIG_W-1:0]  cos_v,
   output logic signed [ddo_pkg::TRIG_W-1:0]  sin_v
);
   import ddo_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     flip_ff, flip_in;
   logic signed [TRIG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0]       z_ff, z_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [32:0]       zs;
   logic signed [TRIG_W-1:0] sh_x, sh_y, x_nx, y_nx;
   logic signed [32:0]       atan_v, z_nx;

   always_comb begin
      zs     = {phase[31], phase};
      atan_v = {1'b0, ATAN_TURN[cnt_ff]};
      sh_x   = x_ff >>> cnt_ff;
      sh_y   = y_ff >>> cnt_ff;
      if (!z_ff[32]) begin
         x_nx = x_ff - sh_y;
         y_nx = y_ff + sh_x;
         z_nx = z_ff - atan_v;
      end else begin
         x_nx = x_ff + sh_y;
         y_nx = y_ff - sh_x;
         z_nx = z_ff + atan_v;
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      flip_in = flip_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = CORDIC_GAIN;
         y_in    = '0;
         // fold into the right half plane; negate both results afterwards
         if (zs > 33'sd1073741824) begin
            z_in    = zs - 33'sd2147483648;
            flip_in = 1'b1;
         end else if (zs < -33'sd1073741824) begin
            z_in    = zs + 33'sd2147483648;
            flip_in = 1'b1;
         end else begin
            z_in    = zs;
            flip_in = 1'b0;
         end
      end else if (busy_ff) begin
         x_in   = x_nx;
         y_in   = y_nx;
         z_in   = z_nx;
         // counter parks on the last step so the table index stays in range
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cos_in  = flip_ff ? -x_nx : x_nx;
            sin_in  = flip_ff ? -y_nx : y_nx;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      flip_ff <= flip_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign done  = done_ff;
   assign cos_v = cos_ff;
   assign sin_v = sin_ff;

endmodule

### dv/differential_drive_odometry_unit_tb.sv
// Testbench of the odometry unit: directed table, random phases, pose predictor.
`timescale 1ns / 1ps
module differential_drive_odometry_unit_tb;
   import ddo_pkg::*;

   localparam int     STEPS     = 16;       // CORDIC iterations of the DUT build
   localparam longint ONE_Q32   = 64'sd4294967296;
   localparam longint PATH_MAX  = 64'sd35184372088832;  // +-2^45, Q16 path clamp
   localparam int     IDLE_PCT  = 37;
   localparam int     HOLD_LEN  = 400;      // long receiver hold-off, cycles
   localparam int     DRAIN_GAP = 200;      // settle time after last result

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [15:0]        h;
   } pose_type;

   // one row of the directed table: either a register write or an encoder beat
   typedef struct {
      bit                 is_csr;
      logic [2:0]         idx;
      logic [23:0]        data;
      logic signed [8:0]  left;
      logic signed [8:0]  right;
      bit                 typed;   // expected pose written into the row
      pose_type           want;
   } row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [8:0]  req_left_ticks;
   logic signed [8:0]  req_right_ticks;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic [15:0]        rsp_heading;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [23:0]        csr_data;

   differential_drive_odometry_unit #(.CORDIC_STEPS(STEPS)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_left_ticks  (req_left_ticks),
      .req_right_ticks (req_right_ticks),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_heading     (rsp_heading),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // ---------------------------------------------------------------- clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------ predictor state
   logic [23:0]        mm_per_tick;
   logic [11:0]        base_mm;
   logic signed [15:0] load_x;
   logic signed [15:0] load_y;
   logic [15:0]        load_h;
   pose_type           pose;

   pose_type pending_poses[$];   // expected result beats, oldest first
   int    mismatches;
   bit    calm;               // no idling on either side while set
   int    hold_asked;
   int    hold_done;
   int    hold_left;

   // Rotation-mode CORDIC on a 32-bit turn phase; Q16 cos/sin out.
   function automatic void rotate_q16(input logic [31:0] phase,
                                      output longint c, output longint s);
      longint z, x, y, t;
      bit     flip;
      z = longint'({32'b0, phase});
      x = longint'(CORDIC_GAIN);
      y = 0;
      flip = 1'b0;
      if (z >= 64'sd2147483648) z = z - ONE_Q32;
      // fold into +-quarter turn; rotating by a half turn negates both outputs
      if (z > 64'sd1073741824) begin
         z = z - 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z = z + 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
         // >>> on a signed longint is a floor shift
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z = z - longint'({32'b0, ATAN_TURN[i]});
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z = z + longint'({32'b0, ATAN_TURN[i]});
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Advance the pose by one encoder beat and return the new pose.
   function automatic pose_type dead_reckon(input logic signed [8:0] lt,
                                            input logic signed [8:0] rt);
      longint     l, r, scale, wb, path, turn, sum, ca, sa, ch, sh, acc;
      logic [63:0] phase;
      l = longint'(lt);
      r = longint'(rt);
      scale = longint'({40'b0, mm_per_tick});
      wb = (base_mm == 12'd0) ? 1 : longint'({52'b0, base_mm});
      if (l == r) begin
         path = l * scale;
      end else begin
         turn = ((r - l) * scale) / wb;    // alpha, radians Q16
         sum = (l + r) * scale;
         if (turn == 0) begin
            path = sum / 2;                 // turn too small to register
         end else begin
            phase = 64'(turn) * 64'd683565276;   // radians to turn fraction
            pose.h = pose.h + phase[47:32];
            rotate_q16(phase[47:16], ca, sa);
            path = (sa * sum) / (2 * turn);
         end
      end
      if (path > PATH_MAX) path = PATH_MAX;
      if (path < -PATH_MAX) path = -PATH_MAX;
      rotate_q16({pose.h, 16'b0}, ch, sh);
      acc = longint'(pose.x) * ONE_Q32 + path * ch;
      pose.x = clamp16(acc / ONE_Q32);
      acc = longint'(pose.y) * ONE_Q32 - path * sh;
      pose.y = clamp16(acc / ONE_Q32);
      return pose;
   endfunction

   function automatic void apply_csr(input logic [2:0] idx, input logic [23:0] data);
      case (idx)
         CSR_TICKS_TO_MM:   mm_per_tick = data;
         CSR_WHEEL_BASE:    base_mm = data[11:0];
         CSR_START_X:       load_x = data[15:0];
         CSR_START_Y:       load_y = data[15:0];
         CSR_START_HEADING: load_h = data[15:0];
         default: ;
      endcase
      // any start-pose write reloads all three pose fields
      if (idx == CSR_START_X || idx == CSR_START_Y || idx == CSR_START_HEADING) begin
         pose.x = load_x;
         pose.y = load_y;
         pose.h = load_h;
      end
   endfunction

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // ------------------------------------------------------ result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_LEN;
         hold_done <= hold_done + 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // compare every accepted result beat with the oldest expected pose
   always @(posedge clock) begin
      pose_type exp_pose;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_poses.size() == 0) begin
            report($sformatf("result beat x=%0d y=%0d h=%0d with nothing pending",
                             rsp_pos_x, rsp_pos_y, rsp_heading));
         end else begin
            exp_pose = pending_poses.pop_front();
            if (rsp_pos_x !== exp_pose.x)
               report($sformatf("pos_x %0d, want %0d", rsp_pos_x, exp_pose.x));
            if (rsp_pos_y !== exp_pose.y)
               report($sformatf("pos_y %0d, want %0d", rsp_pos_y, exp_pose.y));
            if (rsp_heading !== exp_pose.h)
               report($sformatf("heading %0d, want %0d", rsp_heading, exp_pose.h));
         end
      end
   end

   // ------------------------------------------------------ sender helpers
   // Wait until every pending pose has come back, then settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Offer one encoder beat; returns at the edge it is taken.
   task automatic send_beat(input logic signed [8:0] lt, input logic signed [8:0] rt,
                            input bit typed, input pose_type want);
      pose_type next;
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         req_left_ticks <= 9'($urandom);
         req_right_ticks <= 9'($urandom);
         @(posedge clock);
         while ($urandom_range(99) < IDLE_PCT) @(posedge clock);
         // now and then wait for a fully empty pipe
         if ($urandom_range(99) < 3)
            while (pending_poses.size() != 0) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_left_ticks <= lt;
      req_right_ticks <= rt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      next = dead_reckon(lt, rt);
      pending_poses = {pending_poses, (typed ? want : next)};
   endtask

   // Register write; only called with the pipe empty.
   task automatic write_csr(input logic [2:0] idx, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      apply_csr(idx, data);
   endtask

   function automatic row_type beat_row(input int lt, input int rt);
      row_type row;
      row = '{default: '0};
      row.left = 9'(lt);
      row.right = 9'(rt);
      return row;
   endfunction

   function automatic row_type known_row(input int lt, input int rt,
                                         input int x, input int y, input int h);
      row_type row;
      row = beat_row(lt, rt);
      row.typed = 1'b1;
      row.want.x = 16'(x);
      row.want.y = 16'(y);
      row.want.h = 16'(h);
      return row;
   endfunction

   function automatic row_type csr_row(input logic [2:0] idx, input int data);
      row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.idx = idx;
      row.data = 24'(data);
      return row;
   endfunction

   function automatic logic signed [8:0] rand_ticks(input int span);
      return 9'($signed($urandom_range(2 * span)) - span);
   endfunction

   // ------------------------------------------------------ main sequence
   initial begin
      row_type     rows[$];
      row_type     row;
      int          span;
      logic [23:0] scale_pick;
      logic [11:0] base_pick;
      logic signed [8:0] lt;
      reset = 1'b1;
      req_valid = 1'b0;
      req_left_ticks = '0;
      req_right_ticks = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatches = 0;
      calm = 1'b0;
      hold_asked = 0;
      hold_done = 0;
      mm_per_tick = 24'd65536;
      base_mm = 12'd200;
      load_x = '0;
      load_y = '0;
      load_h = '0;
      pose = '{x: 16'sd0, y: 16'sd0, h: 16'd0};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      rows = {rows, known_row(0, 0, 0, 0, 0)};             // pose out of reset
      rows = {rows, beat_row(10, 10)};                      // straight
      rows = {rows, beat_row(-255, -255)};                  // straight back, extreme
      rows = {rows, beat_row(-20, 40)};                     // turning
      rows = {rows, beat_row(255, -255)};                   // spin in place
      rows = {rows, csr_row(CSR_START_X, 24'h00_8000)};     // most negative x
      rows = {rows, csr_row(CSR_START_Y, 24'h00_7fff)};
      rows = {rows, csr_row(CSR_START_HEADING, 24'h00_ffff)};
      rows = {rows, known_row(0, 0, -32768, 32767, 16'hffff)};
      rows = {rows, csr_row(CSR_TICKS_TO_MM, 24'hff_ffff)};  // largest scale
      rows = {rows, beat_row(255, 255)};                    // saturates a position
      rows = {rows, beat_row(-255, 255)};
      rows = {rows, csr_row(CSR_WHEEL_BASE, 24'h000)};      // zero base acts as 1
      rows = {rows, beat_row(100, -37)};
      rows = {rows, csr_row(CSR_WHEEL_BASE, 24'hfff)};
      rows = {rows, csr_row(CSR_TICKS_TO_MM, 24'h00_0001)};
      rows = {rows, beat_row(-3, -2)};                      // turn truncates away
      rows = {rows, beat_row(255, 254)};
      rows = {rows, csr_row(3'd5, 24'h12_3456)};            // index off the map
      rows = {rows, csr_row(3'd7, 24'hff_ffff)};
      rows = {rows, csr_row(CSR_TICKS_TO_MM, 24'h00_0000)};  // zero scale
      rows = {rows, csr_row(CSR_START_HEADING, 24'h00_4000)};
      rows = {rows, known_row(255, -255, -32768, 32767, 16'h4000)};
      rows = {rows, known_row(-255, 200, -32768, 32767, 16'h4000)};

      foreach (rows[i]) begin
         row = rows[i];
         if (row.is_csr) begin
            drain();
            write_csr(row.idx, row.data);
         end else begin
            send_beat(row.left, row.right, row.typed, row.want);
         end
      end

      // random phases: each one picks a scale and a wheel base
      for (int ph = 0; ph < 14; ph++) begin
         drain();
         case (ph % 5)
            0: begin scale_pick = 24'd65536;   base_pick = 12'd200; end
            1: begin scale_pick = 24'hff_ffff; base_pick = 12'd1;   end
            2: begin scale_pick = 24'd1;       base_pick = 12'hfff; end
            3: begin
               scale_pick = 24'($urandom_range(24'hff_ffff, 1));
               base_pick = 12'($urandom_range(12'hfff, 1));
            end
            default: begin
               scale_pick = 24'($urandom_range(24'd400000, 1000));
               base_pick = 12'($urandom_range(12'd600, 60));
            end
         endcase
         write_csr(CSR_TICKS_TO_MM, scale_pick);
         write_csr(CSR_WHEEL_BASE, {12'b0, base_pick});
         if ($urandom_range(1)) begin
            write_csr(CSR_START_X, 24'($urandom));
            write_csr(CSR_START_Y, 24'($urandom));
            write_csr(CSR_START_HEADING, 24'($urandom));
         end
         calm = (ph == 4);          // one phase with no idling on either side
         if (ph == 6 || ph == 11) hold_asked++;   // long receiver hold-off
         span = (ph % 3 == 0) ? 255 : 40;
         repeat (50) begin
            // mostly ordinary driving; some straight runs, some extremes
            case ($urandom_range(9))
               0: begin
                  lt = rand_ticks(span);
                  send_beat(lt, lt, 1'b0, pose);
               end
               1: send_beat($urandom_range(1) ? 9'sd255 : -9'sd255,
                            $urandom_range(1) ? 9'sd255 : -9'sd255, 1'b0, pose);
               default: send_beat(rand_ticks(span), rand_ticks(span), 1'b0, pose);
            endcase
         end
         calm = 1'b0;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // hard stop: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
